[rtl/core/ruidc_pkg.sv]
package ruidc_pkg;

   localparam int SET_CAPACITY = 16;
   localparam int ID_BITS      = 24;
   localparam int COORD_BITS   = 12;
   localparam int FILL_BITS    = $clog2(SET_CAPACITY + 1);
   localparam int DIM_BITS     = 13;
   localparam int RECT_BITS    = 16;
   localparam int CSR_BITS     = 16;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_RECT_LEFT    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_RECT_RIGHT   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_RECT_TOP     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_RECT_BOTTOM  = 3'd5;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_FLUSH,
      ST_EMIT_INSIDE,
      ST_EMIT_BORDER
   } ruidc_state_type;

   typedef struct packed {
      logic pix_accept;
      logic emit_inside;
      logic emit_border;
      logic emit_marker;
      logic emit_last;
      logic clear_marks;
   } ruidc_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic out_free;
      logic inside_empty;
      logic inside_one;
      logic border_empty;
      logic border_one;
   } ruidc_status_type;

endpackage

[rtl/core/ruidc_sorted_set.sv]
module ruidc_sorted_set (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              ins_en,
   input  logic [ruidc_pkg::ID_BITS-1:0]     ins_id,
   input  logic                              pop_en,
   output logic [ruidc_pkg::ID_BITS-1:0]     head,
   output logic [ruidc_pkg::FILL_BITS-1:0]   fill,
   output logic                              dropped
);
   import ruidc_pkg::*;

   logic [ID_BITS-1:0]   set_ff [SET_CAPACITY];
   logic [ID_BITS-1:0]   set_in [SET_CAPACITY];
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic [SET_CAPACITY-1:0] lt;
   logic [SET_CAPACITY-1:0] eq;
   logic dup;
   logic full;
   logic do_ins;

   // per-entry compares against the live part of the set
   always_comb begin
      for (int i = 0; i < SET_CAPACITY; i++) begin
         lt[i] = (FILL_BITS'(i) < fill_ff) && (set_ff[i] < ins_id);
         eq[i] = (FILL_BITS'(i) < fill_ff) && (set_ff[i] == ins_id);
      end
   end

   assign dup     = |eq;
   assign full    = (fill_ff == FILL_BITS'(SET_CAPACITY));
   assign do_ins  = ins_en && !dup && !full;
   assign dropped = ins_en && !dup && full;

   always_comb begin
      fill_in = fill_ff;
      for (int k = 0; k < SET_CAPACITY; k++) begin
         set_in[k] = set_ff[k];
      end
      if (do_ins) begin
         fill_in = fill_ff + 1'b1;
         set_in[0] = lt[0] ? set_ff[0] : ins_id;
         for (int k = 1; k < SET_CAPACITY; k++) begin
            if (lt[k]) begin
               set_in[k] = set_ff[k];
            end else if (lt[k-1]) begin
               set_in[k] = ins_id;
            end else begin
               set_in[k] = set_ff[k-1];
            end
         end
      end else if (pop_en) begin
         fill_in = fill_ff - 1'b1;
         for (int k = 0; k < SET_CAPACITY - 1; k++) begin
            set_in[k] = set_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SET_CAPACITY; k++) begin
         set_ff[k] <= set_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign head = set_ff[0];
   assign fill = fill_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(SET_CAPACITY))
      else $error("set fill beyond capacity");

   a_no_ins_pop: assert property (@(posedge clock) disable iff (reset)
      !(ins_en && pop_en))
      else $error("insert and pop in the same cycle");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (fill_ff >= FILL_BITS'(2)) |-> (set_ff[0] < set_ff[1]))
      else $error("set head out of order");

endmodule

[rtl/core/ruidc_datapath.sv]
module ruidc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ruidc_pkg::ruidc_cmd_type             cmd,
   output ruidc_pkg::ruidc_status_type          status,
   input  logic                                 csr_write_enable,
   input  logic [ruidc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ruidc_pkg::CSR_BITS-1:0]       csr_data,
   input  logic [ruidc_pkg::ID_BITS-1:0]        req_pixel_id,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [ruidc_pkg::ID_BITS-1:0]        rsp_object_id,
   output logic                                 rsp_which_set,
   output logic                                 rsp_entry_valid,
   output logic                                 rsp_overflowed,
   output logic                                 rsp_last_of_run
);
   import ruidc_pkg::*;

   localparam logic [DIM_BITS-1:0] MAX_FRAME = DIM_BITS'(1) << COORD_BITS;

   logic [DIM_BITS-1:0]  frame_width_ff;
   logic [DIM_BITS-1:0]  frame_height_ff;
   logic [RECT_BITS-1:0] rect_left_ff;
   logic [RECT_BITS-1:0] rect_right_ff;
   logic [RECT_BITS-1:0] rect_top_ff;
   logic [RECT_BITS-1:0] rect_bottom_ff;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;

   logic                 pipe_valid_ff;
   logic [ID_BITS-1:0]   pipe_id_ff;
   logic                 pipe_inside_ff;
   logic                 pipe_border_ff;

   logic [1:0]           marks_ff, marks_in;

   logic                 out_valid_ff;
   logic [ID_BITS-1:0]   out_id_ff;
   logic                 out_which_ff;
   logic                 out_entry_ff;
   logic                 out_ovf_ff;
   logic                 out_last_ff;

   logic [DIM_BITS-1:0]   w, h;
   logic [COORD_BITS-1:0] w_m1, h_m1;
   logic [COORD_BITS-1:0] x_lo, x_hi;
   logic [DIM_BITS-1:0]   y_lo, y_hi;
   logic [DIM_BITS-1:0]   r_ext;
   logic                  in_rect, on_border, row_end, frame_end;

   logic [ID_BITS-1:0]    inside_head, border_head;
   logic [FILL_BITS-1:0]  inside_fill, border_fill;
   logic                  inside_drop, border_drop;
   logic                  out_load, out_free;

   function automatic logic [DIM_BITS-1:0] frame_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] d;
      d = v;
      if (v == '0) begin
         d = DIM_BITS'(1);
      end else if (v > MAX_FRAME) begin
         d = MAX_FRAME;
      end
      return d;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [RECT_BITS-1:0] v,
                                                        input logic [COORD_BITS-1:0] hi);
      logic [COORD_BITS-1:0] c;
      c = v[COORD_BITS-1:0];
      if (v[RECT_BITS-1]) begin
         c = '0;
      end else if (v[RECT_BITS-2:0] > {{(RECT_BITS-1-COORD_BITS){1'b0}}, hi}) begin
         c = hi;
      end
      return c;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_BITS'(640);
         frame_height_ff <= DIM_BITS'(480);
         rect_left_ff    <= '0;
         rect_right_ff   <= '0;
         rect_top_ff     <= '0;
         rect_bottom_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[DIM_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[DIM_BITS-1:0];
            REG_RECT_LEFT:    rect_left_ff    <= csr_data;
            REG_RECT_RIGHT:   rect_right_ff   <= csr_data;
            REG_RECT_TOP:     rect_top_ff     <= csr_data;
            REG_RECT_BOTTOM:  rect_bottom_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // window, rows flipped to buffer order
   always_comb begin
      w     = frame_dim(frame_width_ff);
      h     = frame_dim(frame_height_ff);
      w_m1  = COORD_BITS'(w - 1'b1);
      h_m1  = COORD_BITS'(h - 1'b1);
      x_lo  = clamp_coord(rect_left_ff, w_m1);
      x_hi  = clamp_coord(rect_right_ff, w_m1);
      y_lo  = h - {1'b0, clamp_coord(rect_bottom_ff, h_m1)};
      y_hi  = h - {1'b0, clamp_coord(rect_top_ff, h_m1)};
      r_ext = {1'b0, row_ff};
      in_rect   = (r_ext >= y_lo) && (r_ext < y_hi) && (col_ff >= x_lo) && (col_ff < x_hi);
      on_border = (r_ext == y_lo) || (r_ext == (y_hi - 1'b1)) ||
                  (col_ff == x_lo) || (col_ff == (x_hi - 1'b1));
      row_end   = (col_ff >= w_m1);
      frame_end = row_end && (row_ff >= h_m1);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.pix_accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         pipe_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         pipe_valid_ff <= cmd.pix_accept;
      end
   end

   // stage register between window test and sorted insert
   always_ff @(posedge clock) begin
      if (cmd.pix_accept) begin
         pipe_id_ff     <= req_pixel_id;
         pipe_inside_ff <= in_rect;
         pipe_border_ff <= in_rect && on_border;
      end
   end

   ruidc_sorted_set u_inside_set (
      .clock   (clock),
      .reset   (reset),
      .ins_en  (pipe_valid_ff && pipe_inside_ff),
      .ins_id  (pipe_id_ff),
      .pop_en  (cmd.emit_inside),
      .head    (inside_head),
      .fill    (inside_fill),
      .dropped (inside_drop)
   );

   ruidc_sorted_set u_border_set (
      .clock   (clock),
      .reset   (reset),
      .ins_en  (pipe_valid_ff && pipe_border_ff),
      .ins_id  (pipe_id_ff),
      .pop_en  (cmd.emit_border),
      .head    (border_head),
      .fill    (border_fill),
      .dropped (border_drop)
   );

   always_comb begin
      marks_in = marks_ff;
      if (cmd.clear_marks) begin
         marks_in = '0;
      end
      if (inside_drop) begin
         marks_in[0] = 1'b1;
      end
      if (border_drop) begin
         marks_in[1] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
      end else begin
         marks_ff <= marks_in;
      end
   end

   // output word register
   assign out_load = cmd.emit_inside || cmd.emit_border || cmd.emit_marker;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_id_ff    <= cmd.emit_inside ? inside_head :
                         cmd.emit_border ? border_head : '0;
         out_which_ff <= cmd.emit_border;
         out_entry_ff <= !cmd.emit_marker;
         out_ovf_ff   <= cmd.emit_inside ? marks_ff[0] :
                         cmd.emit_border ? marks_ff[1] : 1'b0;
         out_last_ff  <= cmd.emit_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_object_id   = out_id_ff;
   assign rsp_which_set   = out_which_ff;
   assign rsp_entry_valid = out_entry_ff;
   assign rsp_overflowed  = out_ovf_ff;
   assign rsp_last_of_run = out_last_ff;

   always_comb begin
      status.frame_end    = frame_end;
      status.out_free     = out_free;
      status.inside_empty = (inside_fill == '0);
      status.inside_one   = (inside_fill == FILL_BITS'(1));
      status.border_empty = (border_fill == '0);
      status.border_one   = (border_fill == FILL_BITS'(1));
   end

   a_no_insert_in_emit: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !pipe_valid_ff)
      else $error("insert pending while sets are emitted");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output word overwritten while stalled");

   a_marker_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_marker |-> (border_fill == '0) && cmd.emit_last)
      else $error("empty-frame marker with border entries");

endmodule

[rtl/core/ruidc_ctrl.sv]
module ruidc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ruidc_pkg::ruidc_status_type  status,
   output ruidc_pkg::ruidc_cmd_type     cmd
);
   import ruidc_pkg::*;

   ruidc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid && status.frame_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_EMIT_INSIDE;
         end
         ST_EMIT_INSIDE: begin
            if (status.out_free) begin
               if (status.inside_empty) begin
                  state_in = ST_COLLECT;
               end else if (status.inside_one) begin
                  state_in = status.border_empty ? ST_COLLECT : ST_EMIT_BORDER;
               end
            end
         end
         ST_EMIT_BORDER: begin
            if (status.out_free && status.border_one) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_COLLECT: begin
            req_stall      = 1'b0;
            cmd.pix_accept = req_valid;
         end
         ST_FLUSH: ;
         ST_EMIT_INSIDE: begin
            if (status.out_free) begin
               if (status.inside_empty) begin
                  cmd.emit_marker = 1'b1;
                  cmd.emit_last   = 1'b1;
               end else begin
                  cmd.emit_inside = 1'b1;
                  cmd.emit_last   = status.inside_one && status.border_empty;
               end
            end
         end
         ST_EMIT_BORDER: begin
            if (status.out_free) begin
               cmd.emit_border = 1'b1;
               cmd.emit_last   = status.border_one;
            end
         end
         default: ;
      endcase
      // overflow marks live until the frame's final word is loaded
      cmd.clear_marks = cmd.emit_last;
   end

endmodule

[rtl/core/region_unique_id_collector_core.sv]
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_pixel_id
// rsp       out        rsp_valid/rsp_stall  rsp_object_id, rsp_which_set, rsp_entry_valid,
//                                           rsp_overflowed, rsp_last_of_run
// csr       in         csr_write_enable     csr_index, csr_data
//
// one pixel word per cycle while a frame is collected; the sorted insert is one stage behind
// after the frame's last pixel, req_stall is high through the flush state and the emission of the
// result words (1 to 32), each result taken from the heads of the two sets
// rsp_stall holds the output register; during emission each stalled cycle keeps req_stall high
// synchronous reset restores the register defaults and empties both sets
module region_unique_id_collector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ruidc_pkg::ID_BITS-1:0]        req_pixel_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ruidc_pkg::ID_BITS-1:0]        rsp_object_id,
   output logic                                 rsp_which_set,
   output logic                                 rsp_entry_valid,
   output logic                                 rsp_overflowed,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_write_enable,
   input  logic [ruidc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ruidc_pkg::CSR_BITS-1:0]       csr_data
);
   import ruidc_pkg::*;

   ruidc_cmd_type    cmd;
   ruidc_status_type status;

   ruidc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ruidc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pixel_id     (req_pixel_id),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_object_id    (rsp_object_id),
      .rsp_which_set    (rsp_which_set),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
